// ----- hdl/brcr_pkg.sv -----
`timescale 1ns / 1ps

package brcr_pkg;

  localparam int CURRENT_BITS_DEF = 16;
  localparam int STEP_BITS        = 15;
  localparam logic [STEP_BITS-1:0] STEP_RESET = 15'd10;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_POLARITY = 3'd1,
    ACT_OFF      = 3'd2,
    ACT_POWER_ON = 3'd3,
    ACT_SET      = 3'd4,
    ACT_DONE     = 3'd5
  } action_t;

  // Decision flags handed from the decision logic to the result register
  typedef struct packed {
    action_t action;
    logic    polarity_cmd;
    logic    done_notice;
    logic    busy_res;
  } dec_t;

endpackage

// ----- hdl/bipolar_current_ramp_controller.sv -----
`timescale 1ns / 1ps

// Bipolar current ramp controller.
// Input channel (in_*): one request per timer tick or target update. A tick
// carries the supply's programmed magnitude, its output-on flag, the relay
// state and the measuring flag; a target update carries the signed target.
// Output channel (out_*): exactly one result per request, in order, giving
// the supply/relay action to perform and the sweeping flag afterwards.
// Config channel (cfg_*): writes step_size; write only while the block is idle.
// A request passes through the input register, then the decision logic into
// the result register, where out_valid rises. Throughput is one request per
// cycle while out_ready stays high; the target and sweep registers update
// as each request moves from the input register into the result register.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready drops only when both are occupied and out_ready is low.
// Reset clears target to zero, ends any sweep, empties both stages and loads
// step_size with 10 mA.
module bipolar_current_ramp_controller #(
  parameter int CURRENT_BITS = brcr_pkg::CURRENT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_operation,
  input  logic signed [CURRENT_BITS-1:0]        in_new_target,
  input  logic        [CURRENT_BITS-2:0]        in_supply_setpoint,
  input  logic                                  in_supply_on,
  input  logic                                  in_relay_crossed,
  input  logic                                  in_measuring,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [2:0]                     out_action,
  output logic                                  out_polarity_cmd,
  output logic        [CURRENT_BITS-2:0]        out_current_cmd,
  output logic                                  out_done_notice,
  output logic                                  out_busy_res,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [brcr_pkg::STEP_BITS-1:0] cfg_step_size
);

  logic                              s1_valid_r;
  logic                              s1_op_r;
  logic signed [CURRENT_BITS-1:0]    s1_target_r;
  logic        [CURRENT_BITS-2:0]    s1_setpoint_r;
  logic                              s1_on_r;
  logic                              s1_crossed_r;
  logic                              s1_meas_r;
  logic                              s1_adv;

  logic signed [CURRENT_BITS-1:0]    target_r;
  logic signed [CURRENT_BITS-1:0]    target_nxt;
  logic                              sweep_r;
  logic                              sweep_nxt;
  logic        [brcr_pkg::STEP_BITS-1:0] step_r;

  brcr_pkg::dec_t                    dec;
  brcr_pkg::dec_t                    res_r;
  logic        [CURRENT_BITS-2:0]    cur_cmd;
  logic        [CURRENT_BITS-2:0]    cur_cmd_r;
  logic                              out_valid_r;

  // Advance the input register into the result register when it is free
  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  brcr_decide #(
    .CURRENT_BITS(CURRENT_BITS)
  ) u_decide (
    .operation       (s1_op_r),
    .new_target      (s1_target_r),
    .supply_setpoint (s1_setpoint_r),
    .supply_on       (s1_on_r),
    .relay_crossed   (s1_crossed_r),
    .measuring       (s1_meas_r),
    .target_cur      (target_r),
    .sweep_cur       (sweep_r),
    .step_size       (step_r),
    .target_nxt      (target_nxt),
    .sweep_nxt       (sweep_nxt),
    .dec             (dec),
    .current_cmd     (cur_cmd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      target_r    <= '0;
      sweep_r     <= 1'b0;
      step_r      <= brcr_pkg::STEP_RESET;
    end else begin
      if (cfg_valid) begin
        step_r <= cfg_step_size;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          target_r <= target_nxt;
          sweep_r  <= sweep_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r       <= in_operation;
      s1_target_r   <= in_new_target;
      s1_setpoint_r <= in_supply_setpoint;
      s1_on_r       <= in_supply_on;
      s1_crossed_r  <= in_relay_crossed;
      s1_meas_r     <= in_measuring;
    end
    if (s1_adv && s1_valid_r) begin
      res_r     <= dec;
      cur_cmd_r <= cur_cmd;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = res_r.action;
  assign out_polarity_cmd = res_r.polarity_cmd;
  assign out_current_cmd  = cur_cmd_r;
  assign out_done_notice  = res_r.done_notice;
  assign out_busy_res     = res_r.busy_res;

endmodule

// ----- hdl/brcr_decide.sv -----
`timescale 1ns / 1ps

module brcr_decide #(
  parameter int CURRENT_BITS = brcr_pkg::CURRENT_BITS_DEF
) (
  input  logic                              operation,
  input  logic signed [CURRENT_BITS-1:0]    new_target,
  input  logic        [CURRENT_BITS-2:0]    supply_setpoint,
  input  logic                              supply_on,
  input  logic                              relay_crossed,
  input  logic                              measuring,
  input  logic signed [CURRENT_BITS-1:0]    target_cur,
  input  logic                              sweep_cur,
  input  logic        [brcr_pkg::STEP_BITS-1:0] step_size,
  output logic signed [CURRENT_BITS-1:0]    target_nxt,
  output logic                              sweep_nxt,
  output brcr_pkg::dec_t                    dec,
  output logic        [CURRENT_BITS-2:0]    current_cmd
);

  localparam int SB = brcr_pkg::STEP_BITS;
  localparam int D  = ((CURRENT_BITS > SB + 1) ? CURRENT_BITS : SB + 1) + 2;

  logic                want_cross;
  logic                want_power;
  logic                relay_wrong;
  logic        [D-1:0] mag_x;
  logic        [D-1:0] step_x;
  logic        [D-1:0] mag_max_x;
  logic signed [D-1:0] p;
  logic signed [D-1:0] tgt_x;
  logic signed [D-1:0] diff;
  logic        [D-1:0] diff_abs;
  logic signed [D-1:0] p_step;
  logic        [D-1:0] p_step_abs;
  logic        [CURRENT_BITS-2:0] p_sat;

  assign want_cross  = target_cur[CURRENT_BITS-1];
  assign want_power  = |target_cur;
  assign relay_wrong = relay_crossed != want_cross;

  assign mag_x     = {{(D-CURRENT_BITS+1){1'b0}}, supply_setpoint};
  assign step_x    = {{(D-SB){1'b0}}, step_size};
  assign mag_max_x = {{(D-CURRENT_BITS+1){1'b0}}, {(CURRENT_BITS-1){1'b1}}};
  assign p         = relay_crossed ? -signed'(mag_x) : signed'(mag_x);
  assign tgt_x     = {{(D-CURRENT_BITS){target_cur[CURRENT_BITS-1]}}, target_cur};
  assign diff      = p - tgt_x;
  assign diff_abs  = diff[D-1] ? unsigned'(-diff) : unsigned'(diff);

  // Move one step toward the target, then take the magnitude and clamp it
  assign p_step     = (p > tgt_x) ? (p - signed'(step_x)) : (p + signed'(step_x));
  assign p_step_abs = p_step[D-1] ? unsigned'(-p_step) : unsigned'(p_step);
  assign p_sat      = (p_step_abs > mag_max_x) ? mag_max_x[CURRENT_BITS-2:0]
                                               : p_step_abs[CURRENT_BITS-2:0];

  always_comb begin
    target_nxt       = target_cur;
    sweep_nxt        = sweep_cur;
    dec.action       = brcr_pkg::ACT_NONE;
    dec.polarity_cmd = 1'b0;
    dec.done_notice  = 1'b0;
    current_cmd      = '0;
    if (operation) begin
      if (new_target != target_cur) begin
        target_nxt = new_target;
        sweep_nxt  = 1'b1;
      end
    end else if (sweep_cur) begin
      priority if (relay_wrong && !supply_on) begin
        dec.action       = brcr_pkg::ACT_POLARITY;
        dec.polarity_cmd = want_cross;
      end else if (relay_wrong && (mag_x < step_x)) begin
        dec.action = brcr_pkg::ACT_OFF;
      end else if (diff_abs < step_x) begin
        if (!want_power && (mag_x <= step_x) && supply_on) begin
          dec.action = brcr_pkg::ACT_OFF;
        end else begin
          dec.action      = brcr_pkg::ACT_DONE;
          dec.done_notice = !measuring;
          sweep_nxt       = 1'b0;
        end
      end else if (!supply_on && want_power) begin
        dec.action = brcr_pkg::ACT_POWER_ON;
      end else begin
        dec.action  = brcr_pkg::ACT_SET;
        current_cmd = p_sat;
      end
    end
    dec.busy_res = sweep_nxt;
  end

endmodule
